// ===== rtl/lavm_pkg.sv =====
`timescale 1ns / 1ps
// lavm_pkg: shared widths, types and helper functions of the look-at view matrix core
package lavm_pkg;

	localparam int WORD_BITS  = 32;
	localparam int FRAC_BITS  = 16;
	localparam int MUL_BITS   = 32;
	localparam int PROD_BITS  = 2 * MUL_BITS;
	localparam int MAG_BITS   = 64;
	localparam int DIFF_BITS  = WORD_BITS + 1;
	localparam int SCALE_LO   = 29;
	localparam int SCALE_HI   = 30;
	localparam int ROOT_BITS  = 64;
	localparam int SQRT_STEPS = 32;
	localparam int LEN_BITS   = 32;
	localparam int QUO_BITS   = FRAC_BITS + 1;
	localparam int DIV_STEPS  = QUO_BITS;
	localparam int ACC_BITS   = PROD_BITS + 2;
	localparam int CNT_BITS   = $clog2(SQRT_STEPS);
	localparam int IDX_BITS   = 4;
	localparam int CROSS_ISSUES = 6;
	localparam int SQ_ISSUES    = 3;
	localparam int TRANS_ISSUES = 9;
	localparam int LAST_COMP    = 2;

	typedef logic signed [WORD_BITS-1:0] word_t;

	typedef enum logic [1:0] {VS_DIFF, VS_HINT, VS_FWD} vsrc_t;
	typedef enum logic [1:0] {XS_HINT_FWD, XS_FWD_RGT, XS_UPW_FWD} xsel_t;
	typedef enum logic [1:0] {DST_RGT, DST_UPW, DST_FWD} dst_t;
	typedef enum logic [1:0] {MM_CROSS, MM_SQ, MM_TRANS} mmode_t;

	typedef enum logic [2:0] {
		STEP_LA_FWD, STEP_LA_HINT, STEP_LA_RGT, STEP_LA_UPW,
		STEP_FWD, STEP_UPW, STEP_RGT, STEP_SHIFT
	} step_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_VLOAD, ST_SCALE, ST_HINT_WR, ST_SQ, ST_ROOT_INIT, ST_ROOT,
		ST_DIV_INIT, ST_DIV_RUN, ST_DIV_WR, ST_ZERO_WR, ST_CROSS, ST_XSHIFT,
		ST_TRANS, ST_OUT
	} state_t;

	typedef struct packed {
		logic                load;
		logic                vload;
		vsrc_t               vsrc;
		logic                scale;
		logic                hint_wr;
		logic                mul_go;
		mmode_t              mmode;
		xsel_t               xsel;
		logic [IDX_BITS-1:0] idx;
		logic                root_init;
		logic                root_step;
		logic                div_init;
		logic                div_step;
		logic [1:0]          comp;
		logic                div_wr;
		logic                zero_wr;
		logic                xs_wr;
		dst_t                dst;
		logic                out_load;
	} cmd_t;

	typedef struct packed {
		logic v_zero;
		logic scale_ok;
	} sts_t;

	// magnitude of a signed word (most negative value maps to 2^(W-1))
	function automatic logic [WORD_BITS-1:0] to_mag(word_t v);
		logic [WORD_BITS-1:0] u;
		u = v;
		return v[WORD_BITS-1] ? (~u + 1'b1) : u;
	endfunction

	// limit a magnitude to 2^(MUL_BITS-1) before the cross products
	function automatic logic [MUL_BITS-1:0] clamp_mul(logic [WORD_BITS-1:0] mag);
		logic [WORD_BITS-1:0] lim;
		lim = WORD_BITS'(1) << (MUL_BITS - 1);
		return (mag > lim) ? MUL_BITS'(lim) : MUL_BITS'(mag);
	endfunction

	// sign-magnitude to signed word, saturating
	function automatic word_t sat_mag(logic neg, logic [MAG_BITS-1:0] mag);
		logic [MAG_BITS-1:0] lim;
		word_t r;
		if (neg) begin
			lim = MAG_BITS'(1) << (WORD_BITS - 1);
			r = (mag > lim) ? {1'b1, {(WORD_BITS-1){1'b0}}}
			                : word_t'(~mag[WORD_BITS-1:0] + 1'b1);
		end else begin
			lim = (MAG_BITS'(1) << (WORD_BITS - 1)) - 1'b1;
			r = (mag > lim) ? {1'b0, {(WORD_BITS-1){1'b1}}} : word_t'(mag[WORD_BITS-1:0]);
		end
		return r;
	endfunction

	// component of the first operand used by cross product term idx
	function automatic logic [1:0] cross_a_comp(logic [IDX_BITS-1:0] idx);
		logic [1:0] c;
		case (idx)
			4'd0: c = 2'd1;
			4'd1: c = 2'd2;
			4'd2: c = 2'd2;
			4'd3: c = 2'd0;
			4'd4: c = 2'd0;
			4'd5: c = 2'd1;
			default: c = 2'd0;
		endcase
		return c;
	endfunction

	// component of the second operand used by cross product term idx
	function automatic logic [1:0] cross_b_comp(logic [IDX_BITS-1:0] idx);
		logic [1:0] c;
		case (idx)
			4'd0: c = 2'd2;
			4'd1: c = 2'd1;
			4'd2: c = 2'd0;
			4'd3: c = 2'd2;
			4'd4: c = 2'd1;
			4'd5: c = 2'd0;
			default: c = 2'd0;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] trans_axis(logic [IDX_BITS-1:0] idx);
		logic [1:0] a;
		case (idx)
			4'd0, 4'd1, 4'd2: a = 2'd0;
			4'd3, 4'd4, 4'd5: a = 2'd1;
			default:          a = 2'd2;
		endcase
		return a;
	endfunction

	function automatic logic [1:0] trans_comp(logic [IDX_BITS-1:0] idx);
		logic [1:0] c;
		case (idx)
			4'd0, 4'd3, 4'd6: c = 2'd0;
			4'd1, 4'd4, 4'd7: c = 2'd1;
			default:          c = 2'd2;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/lavm_ctrl.sv =====
`timescale 1ns / 1ps
// lavm_ctrl: sequencer that walks the datapath through basis build, normalize and translate
module lavm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            operation,
	output logic            out_valid,
	input  logic            out_ready,
	input  lavm_pkg::sts_t  sts,
	output lavm_pkg::cmd_t  cmd
);
	import lavm_pkg::*;

	state_t              state_q, state_d;
	step_t               step_q, step_d;
	logic [CNT_BITS-1:0] cnt_q, cnt_d;
	logic [1:0]          comp_q, comp_d;
	logic                out_valid_q;

	function automatic state_t first_state(step_t s);
		state_t r;
		case (s)
			STEP_LA_FWD, STEP_LA_HINT, STEP_FWD: r = ST_VLOAD;
			STEP_SHIFT:                          r = ST_TRANS;
			default:                             r = ST_CROSS;
		endcase
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_LA_FWD;
			cnt_q       <= '0;
			comp_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			cnt_q   <= cnt_d;
			comp_q  <= comp_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cnt_d    = cnt_q;
		comp_d   = comp_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.idx  = cnt_q[IDX_BITS-1:0];
		cmd.comp = comp_q;

		case (step_q)
			STEP_LA_FWD:  cmd.vsrc = VS_DIFF;
			STEP_LA_HINT: cmd.vsrc = VS_HINT;
			default:      cmd.vsrc = VS_FWD;
		endcase
		case (step_q)
			STEP_LA_RGT: cmd.xsel = XS_HINT_FWD;
			STEP_RGT:    cmd.xsel = XS_UPW_FWD;
			default:     cmd.xsel = XS_FWD_RGT;
		endcase
		case (step_q)
			STEP_LA_FWD, STEP_FWD: cmd.dst = DST_FWD;
			STEP_LA_RGT, STEP_RGT: cmd.dst = DST_RGT;
			default:               cmd.dst = DST_UPW;
		endcase

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					step_d   = operation ? STEP_FWD : STEP_LA_FWD;
					state_d  = first_state(step_d);
					cnt_d    = '0;
				end
			end
			ST_VLOAD: begin
				cmd.vload = 1'b1;
				state_d   = ST_SCALE;
			end
			ST_SCALE: begin
				cnt_d = '0;
				if (sts.v_zero) begin
					state_d = (step_q == STEP_LA_HINT) ? ST_HINT_WR : ST_ZERO_WR;
				end else if (sts.scale_ok) begin
					state_d = (step_q == STEP_LA_HINT) ? ST_HINT_WR : ST_SQ;
				end else begin
					cmd.scale = 1'b1;
				end
			end
			ST_HINT_WR, ST_ZERO_WR, ST_XSHIFT: begin
				cmd.hint_wr = (state_q == ST_HINT_WR);
				cmd.zero_wr = (state_q == ST_ZERO_WR);
				cmd.xs_wr   = (state_q == ST_XSHIFT);
				step_d      = step_t'(3'(step_q) + 3'd1);
				state_d     = first_state(step_d);
				cnt_d       = '0;
			end
			ST_SQ: begin
				cmd.mmode  = MM_SQ;
				cmd.mul_go = (cnt_q < CNT_BITS'(SQ_ISSUES));
				if (cnt_q == CNT_BITS'(SQ_ISSUES)) begin
					state_d = ST_ROOT_INIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_ROOT_INIT: begin
				cmd.root_init = 1'b1;
				cnt_d         = '0;
				state_d       = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (cnt_q == CNT_BITS'(SQRT_STEPS - 1)) begin
					comp_d  = '0;
					state_d = ST_DIV_INIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_BITS'(DIV_STEPS - 1)) begin
					state_d = ST_DIV_WR;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DIV_WR: begin
				cmd.div_wr = 1'b1;
				if (comp_q == 2'(LAST_COMP)) begin
					step_d  = step_t'(3'(step_q) + 3'd1);
					state_d = first_state(step_d);
					cnt_d   = '0;
				end else begin
					comp_d  = comp_q + 1'b1;
					state_d = ST_DIV_INIT;
				end
			end
			ST_CROSS: begin
				cmd.mmode  = MM_CROSS;
				cmd.mul_go = (cnt_q < CNT_BITS'(CROSS_ISSUES));
				if (cnt_q == CNT_BITS'(CROSS_ISSUES)) begin
					cnt_d   = '0;
					state_d = (step_q == STEP_LA_UPW || step_q == STEP_RGT) ? ST_XSHIFT
					                                                        : ST_SCALE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_TRANS: begin
				cmd.mmode  = MM_TRANS;
				cmd.mul_go = (cnt_q < CNT_BITS'(TRANS_ISSUES));
				if (cnt_q == CNT_BITS'(TRANS_ISSUES)) begin
					state_d = ST_OUT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/lavm_datapath.sv =====
`timescale 1ns / 1ps
// lavm_datapath: basis registers, work vector, shared multiplier, square root and divider
module lavm_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  lavm_pkg::cmd_t  cmd,
	output lavm_pkg::sts_t  sts,
	input  lavm_pkg::word_t pos_x,
	input  lavm_pkg::word_t pos_y,
	input  lavm_pkg::word_t pos_z,
	input  lavm_pkg::word_t target_x,
	input  lavm_pkg::word_t target_y,
	input  lavm_pkg::word_t target_z,
	input  lavm_pkg::word_t up_hint_x,
	input  lavm_pkg::word_t up_hint_y,
	input  lavm_pkg::word_t up_hint_z,
	output lavm_pkg::word_t right_x,
	output lavm_pkg::word_t right_y,
	output lavm_pkg::word_t right_z,
	output lavm_pkg::word_t upward_x,
	output lavm_pkg::word_t upward_y,
	output lavm_pkg::word_t upward_z,
	output lavm_pkg::word_t forward_x,
	output lavm_pkg::word_t forward_y,
	output lavm_pkg::word_t forward_z,
	output lavm_pkg::word_t shift_x,
	output lavm_pkg::word_t shift_y,
	output lavm_pkg::word_t shift_z
);
	import lavm_pkg::*;

	word_t pos_in[3], tgt_in[3], hint_in[3];
	word_t eye_q[3], tgt_q[3], hint_q[3];
	word_t rgt_q[3], upw_q[3], fwd_q[3], shf_q[3];
	word_t o_rgt_q[3], o_upw_q[3], o_fwd_q[3], o_shf_q[3];

	logic                v_neg_q[3];
	logic [MAG_BITS-1:0] v_mag_q[3];
	logic                ld_neg[3];
	logic [MAG_BITS-1:0] ld_mag[3];
	logic                v_big, v_small, v_zero;

	logic [MUL_BITS-1:0]  mul_a, mul_b;
	logic                 mul_neg;
	word_t                xa[3], xb[3];
	word_t                opa, opb;
	logic [PROD_BITS-1:0] prod_s1;
	logic                 neg_s1, go_s1;
	logic [IDX_BITS-1:0]  idx_s1;
	mmode_t               mode_s1;

	logic [1:0]           cc;
	logic                 cx_neg;
	logic [MAG_BITS-1:0]  cx_mag, cx_pm, cx_qm;

	logic [ROOT_BITS-1:0] sum_q, rx_q, res_q, bit_q, r_try;
	logic [LEN_BITS:0]    div_r_q, div_rn;
	logic [QUO_BITS-1:0]  div_q_q;
	logic [LEN_BITS-1:0]  len;
	logic                 div_ge;
	word_t                div_val;

	logic signed [ACC_BITS-1:0] tacc_q, t_prod, t_contrib, t_sum;
	word_t                      t_sat;

	assign pos_in  = '{pos_x, pos_y, pos_z};
	assign tgt_in  = '{target_x, target_y, target_z};
	assign hint_in = '{up_hint_x, up_hint_y, up_hint_z};

	// floor shift of the accumulated dot product, then clamp to the word range
	function automatic word_t sat_acc(logic signed [ACC_BITS-1:0] a);
		logic signed [ACC_BITS-1:0] sh, hi, lo;
		sh = a >>> FRAC_BITS;
		hi = (ACC_BITS'(1) <<< (WORD_BITS - 1)) - 1;
		lo = -hi - 1;
		if (sh > hi) begin
			return word_t'(hi[WORD_BITS-1:0]);
		end else if (sh < lo) begin
			return word_t'(lo[WORD_BITS-1:0]);
		end
		return word_t'(sh[WORD_BITS-1:0]);
	endfunction

	// work vector load sources and block-scale status
	always_comb begin
		logic signed [DIFF_BITS-1:0] d;
		logic [DIFF_BITS-1:0]        dm;
		v_big   = 1'b0;
		v_small = 1'b1;
		v_zero  = 1'b1;
		for (int i = 0; i < 3; i++) begin
			d  = {eye_q[i][WORD_BITS-1], eye_q[i]} - {tgt_q[i][WORD_BITS-1], tgt_q[i]};
			dm = d[DIFF_BITS-1] ? (~d + 1'b1) : d;
			case (cmd.vsrc)
				VS_DIFF: begin
					ld_neg[i] = d[DIFF_BITS-1];
					ld_mag[i] = MAG_BITS'(dm);
				end
				VS_HINT: begin
					ld_neg[i] = hint_q[i][WORD_BITS-1];
					ld_mag[i] = MAG_BITS'(to_mag(hint_q[i]));
				end
				default: begin
					ld_neg[i] = fwd_q[i][WORD_BITS-1];
					ld_mag[i] = MAG_BITS'(to_mag(fwd_q[i]));
				end
			endcase
			v_big   = v_big | (|v_mag_q[i][MAG_BITS-1:SCALE_HI]);
			v_small = v_small & ~(|v_mag_q[i][MAG_BITS-1:SCALE_LO]);
			v_zero  = v_zero & ~(|v_mag_q[i]);
		end
	end

	assign sts.v_zero   = v_zero;
	assign sts.scale_ok = ~v_big & ~v_small;

	// multiplier operand select
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (cmd.xsel)
				XS_HINT_FWD: begin xa[i] = hint_q[i]; xb[i] = fwd_q[i]; end
				XS_UPW_FWD:  begin xa[i] = upw_q[i];  xb[i] = fwd_q[i]; end
				default:     begin xa[i] = fwd_q[i];  xb[i] = rgt_q[i]; end
			endcase
		end
		opa     = '0;
		opb     = '0;
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		case (cmd.mmode)
			MM_CROSS: begin
				opa     = xa[cross_a_comp(cmd.idx)];
				opb     = xb[cross_b_comp(cmd.idx)];
				mul_a   = clamp_mul(to_mag(opa));
				mul_b   = clamp_mul(to_mag(opb));
				mul_neg = opa[WORD_BITS-1] ^ opb[WORD_BITS-1] ^ cmd.idx[0];
			end
			MM_SQ: begin
				mul_a = v_mag_q[cmd.idx[1:0]][MUL_BITS-1:0];
				mul_b = mul_a;
			end
			MM_TRANS: begin
				case (trans_axis(cmd.idx))
					2'd0:    opa = rgt_q[trans_comp(cmd.idx)];
					2'd1:    opa = upw_q[trans_comp(cmd.idx)];
					default: opa = fwd_q[trans_comp(cmd.idx)];
				endcase
				opb     = eye_q[trans_comp(cmd.idx)];
				mul_a   = MUL_BITS'(to_mag(opa));
				mul_b   = MUL_BITS'(to_mag(opb));
				// negated dot: a term is subtracted when both signs agree
				mul_neg = ~(opa[WORD_BITS-1] ^ opb[WORD_BITS-1]);
			end
			default: begin
				mul_neg = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
		end else begin
			go_s1 <= cmd.mul_go;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		neg_s1  <= mul_neg;
		idx_s1  <= cmd.idx;
		mode_s1 <= cmd.mmode;
	end

	// second product of a cross term merges with the first in sign-magnitude
	always_comb begin
		cc    = idx_s1[2:1];
		cx_pm = v_mag_q[cc];
		cx_qm = MAG_BITS'(prod_s1);
		if (v_neg_q[cc] == neg_s1) begin
			cx_neg = neg_s1;
			cx_mag = cx_pm + cx_qm;
		end else if (cx_pm >= cx_qm) begin
			cx_neg = v_neg_q[cc];
			cx_mag = cx_pm - cx_qm;
		end else begin
			cx_neg = neg_s1;
			cx_mag = cx_qm - cx_pm;
		end
	end

	// translation accumulate
	always_comb begin
		t_prod    = $signed({2'b00, prod_s1});
		t_contrib = neg_s1 ? -t_prod : t_prod;
		t_sum     = ((trans_comp(idx_s1) == 2'd0) ? '0 : tacc_q) + t_contrib;
		t_sat     = sat_acc(t_sum);
	end

	// square root try value and divider step
	always_comb begin
		r_try   = res_q + bit_q;
		len     = res_q[LEN_BITS-1:0];
		div_ge  = (div_r_q >= {1'b0, len});
		div_rn  = div_ge ? (div_r_q - {1'b0, len}) : div_r_q;
		div_val = sat_mag(v_neg_q[cmd.comp], MAG_BITS'(div_q_q));
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tgt_q  <= tgt_in;
			hint_q <= hint_in;
		end else if (cmd.hint_wr) begin
			for (int i = 0; i < 3; i++) begin
				hint_q[i] <= v_neg_q[i] ? word_t'(~v_mag_q[i][WORD_BITS-1:0] + 1'b1)
				                        : word_t'(v_mag_q[i][WORD_BITS-1:0]);
			end
		end

		if (cmd.vload) begin
			v_neg_q <= ld_neg;
			v_mag_q <= ld_mag;
		end else if (cmd.scale) begin
			for (int i = 0; i < 3; i++) begin
				v_mag_q[i] <= v_big ? (v_mag_q[i] >> 1) : (v_mag_q[i] << 1);
			end
		end else if (go_s1 && mode_s1 == MM_CROSS) begin
			if (!idx_s1[0]) begin
				v_neg_q[cc] <= neg_s1;
				v_mag_q[cc] <= MAG_BITS'(prod_s1);
			end else begin
				v_neg_q[cc] <= cx_neg;
				v_mag_q[cc] <= cx_mag;
			end
		end

		if (go_s1 && mode_s1 == MM_SQ) begin
			sum_q <= ((idx_s1 == '0) ? '0 : sum_q) + ROOT_BITS'(prod_s1);
		end

		if (go_s1 && mode_s1 == MM_TRANS) begin
			if (trans_comp(idx_s1) == 2'(LAST_COMP)) begin
				shf_q[trans_axis(idx_s1)] <= t_sat;
			end else begin
				tacc_q <= t_sum;
			end
		end

		if (cmd.root_init) begin
			rx_q  <= sum_q;
			res_q <= '0;
			bit_q <= ROOT_BITS'(1) << (2 * (SQRT_STEPS - 1));
		end else if (cmd.root_step) begin
			if (rx_q >= r_try) begin
				rx_q  <= rx_q - r_try;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end

		if (cmd.div_init) begin
			div_r_q <= (LEN_BITS + 1)'(v_mag_q[cmd.comp]);
			div_q_q <= '0;
		end else if (cmd.div_step) begin
			div_r_q <= {div_rn[LEN_BITS-1:0], 1'b0};
			div_q_q <= {div_q_q[QUO_BITS-2:0], div_ge};
		end

		if (cmd.out_load) begin
			o_rgt_q <= rgt_q;
			o_upw_q <= upw_q;
			o_fwd_q <= fwd_q;
			o_shf_q <= shf_q;
		end
	end

	// camera state: eye position and the three basis axes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				eye_q[i] <= '0;
				rgt_q[i] <= (i == 0) ? sat_mag(1'b0, MAG_BITS'(1) << FRAC_BITS) : '0;
				upw_q[i] <= (i == 1) ? sat_mag(1'b0, MAG_BITS'(1) << FRAC_BITS) : '0;
				fwd_q[i] <= (i == 2) ? sat_mag(1'b0, MAG_BITS'(1) << FRAC_BITS) : '0;
			end
		end else begin
			if (cmd.load) begin
				eye_q <= pos_in;
			end
			for (int i = 0; i < 3; i++) begin
				if (cmd.div_wr && cmd.comp == 2'(i)) begin
					case (cmd.dst)
						DST_RGT: rgt_q[i] <= div_val;
						DST_UPW: upw_q[i] <= div_val;
						default: fwd_q[i] <= div_val;
					endcase
				end else if (cmd.zero_wr) begin
					case (cmd.dst)
						DST_RGT: rgt_q[i] <= '0;
						DST_UPW: upw_q[i] <= '0;
						default: fwd_q[i] <= '0;
					endcase
				end else if (cmd.xs_wr) begin
					case (cmd.dst)
						DST_RGT: rgt_q[i] <= sat_mag(v_neg_q[i], v_mag_q[i] >> FRAC_BITS);
						DST_UPW: upw_q[i] <= sat_mag(v_neg_q[i], v_mag_q[i] >> FRAC_BITS);
						default: fwd_q[i] <= sat_mag(v_neg_q[i], v_mag_q[i] >> FRAC_BITS);
					endcase
				end
			end
		end
	end

	assign right_x   = o_rgt_q[0];
	assign right_y   = o_rgt_q[1];
	assign right_z   = o_rgt_q[2];
	assign upward_x  = o_upw_q[0];
	assign upward_y  = o_upw_q[1];
	assign upward_z  = o_upw_q[2];
	assign forward_x = o_fwd_q[0];
	assign forward_y = o_fwd_q[1];
	assign forward_z = o_fwd_q[2];
	assign shift_x   = o_shf_q[0];
	assign shift_y   = o_shf_q[1];
	assign shift_z   = o_shf_q[2];

endmodule

// ===== rtl/look_at_view_matrix_core.sv =====
`timescale 1ns / 1ps
// look_at_view_matrix_core: top level of the right-handed look-at view matrix unit
//
//   channel | signals                                         | transfer when
//   --------+-------------------------------------------------+------------------------
//   in      | in_valid, in_ready, operation, pos_*, target_*, | in_valid && in_ready
//           | up_hint_*                                       |
//   out     | out_valid, out_ready, right_*, upward_*,        | out_valid && out_ready
//           | forward_*, shift_*                              |
//
// One item at a time. A normalize block-scales the work vector (up to 34 shifts), then
// runs three squares on the shared 32x32 multiplier, 32 root steps and three 17-step
// divisions; a zero vector skips all of these.
// Reset loads the identity basis and a zero eye position; no clearing pass follows.
// in_ready is high only while the sequencer idles; a second result holds in the
// sequencer until the waiting one in the output register transfers.
module look_at_view_matrix_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            operation,
	input  lavm_pkg::word_t pos_x,
	input  lavm_pkg::word_t pos_y,
	input  lavm_pkg::word_t pos_z,
	input  lavm_pkg::word_t target_x,
	input  lavm_pkg::word_t target_y,
	input  lavm_pkg::word_t target_z,
	input  lavm_pkg::word_t up_hint_x,
	input  lavm_pkg::word_t up_hint_y,
	input  lavm_pkg::word_t up_hint_z,
	output logic            out_valid,
	input  logic            out_ready,
	output lavm_pkg::word_t right_x,
	output lavm_pkg::word_t right_y,
	output lavm_pkg::word_t right_z,
	output lavm_pkg::word_t upward_x,
	output lavm_pkg::word_t upward_y,
	output lavm_pkg::word_t upward_z,
	output lavm_pkg::word_t forward_x,
	output lavm_pkg::word_t forward_y,
	output lavm_pkg::word_t forward_z,
	output lavm_pkg::word_t shift_x,
	output lavm_pkg::word_t shift_y,
	output lavm_pkg::word_t shift_z
);
	import lavm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: one command word per cycle, status back from the datapath
	lavm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: camera state, work vector, shared multiplier, root and divider
	lavm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.target_x  (target_x),
		.target_y  (target_y),
		.target_z  (target_z),
		.up_hint_x (up_hint_x),
		.up_hint_y (up_hint_y),
		.up_hint_z (up_hint_z),
		.right_x   (right_x),
		.right_y   (right_y),
		.right_z   (right_z),
		.upward_x  (upward_x),
		.upward_y  (upward_y),
		.upward_z  (upward_z),
		.forward_x (forward_x),
		.forward_y (forward_y),
		.forward_z (forward_z),
		.shift_x   (shift_x),
		.shift_y   (shift_y),
		.shift_z   (shift_z)
	);

endmodule

// ===== tb/tb_look_at_view_matrix_core.sv =====
`timescale 1ns / 1ps
// tb_look_at_view_matrix_core: self-checking testbench of the look-at view matrix core
module tb_look_at_view_matrix_core;
	import lavm_pkg::*;

	localparam logic OP_LOOK_AT = 1'b0;
	localparam logic OP_SET_POS = 1'b1;
	localparam int   HALF_PERIOD = 10;
	localparam int   RANDOM_ITEMS = 1630;
	localparam int   DRAIN_CYCLES = 800;
	localparam int   HOLD_CYCLES = 4000;
	localparam int   HOLD_AT = 1250;
	localparam int   PHASE_A_END = 550;
	localparam int   PHASE_B_END = 1100;
	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -64'sd2147483648;

	// one camera request; vectors are indexed x, y, z
	typedef struct {
		logic   op;
		longint pos[3];
		longint tgt[3];
		longint hint[3];
	} cam_item_t;

	// right, upward, forward, shift; three words each
	typedef logic [11:0][WORD_BITS-1:0] view_t;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	logic  operation;
	word_t pos_x, pos_y, pos_z;
	word_t target_x, target_y, target_z;
	word_t up_hint_x, up_hint_y, up_hint_z;
	logic  out_valid;
	logic  out_ready;
	word_t right_x, right_y, right_z;
	word_t upward_x, upward_y, upward_z;
	word_t forward_x, forward_y, forward_z;
	word_t shift_x, shift_y, shift_z;

	cam_item_t pending_items[$];
	view_t     expected_views[$];
	cam_item_t cur_item;

	// predictor copy of the camera state
	longint cam_rgt[3];
	longint cam_upw[3];
	longint cam_fwd[3];
	longint cam_eye[3];

	bit drive_en;
	int sent_cnt;
	int look_cnt;
	int setpos_cnt;
	int checked_cnt;
	int mismatch_cnt;
	int snd_idle_pct;
	int rcv_idle_pct;
	int hold_left;
	bit hold_done;
	int stall_cnt;

	look_at_view_matrix_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.target_x(target_x), .target_y(target_y), .target_z(target_z),
		.up_hint_x(up_hint_x), .up_hint_y(up_hint_y), .up_hint_z(up_hint_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.right_x(right_x), .right_y(right_y), .right_z(right_z),
		.upward_x(upward_x), .upward_y(upward_y), .upward_z(upward_z),
		.forward_x(forward_x), .forward_y(forward_y), .forward_z(forward_z),
		.shift_x(shift_x), .shift_y(shift_y), .shift_z(shift_z)
	);

	// ---------------------------------------------------------------- predictor
	function automatic logic [63:0] abs64(longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	// sign-magnitude to the signed word range, saturating
	function automatic longint clip_word(bit neg, logic [63:0] mag);
		if (neg)
			return (mag > 64'h8000_0000) ? WORD_MIN : -longint'(mag);
		return (mag > 64'h7FFF_FFFF) ? WORD_MAX : longint'(mag);
	endfunction

	// shift all three magnitudes together until the largest is in [2^29, 2^30)
	function automatic bit block_align(inout logic [63:0] m[3]);
		logic [63:0] top;
		top = m[0];
		if (m[1] > top) top = m[1];
		if (m[2] > top) top = m[2];
		if (top == 0) return 1'b0;
		while (top >= (64'd1 << SCALE_HI)) begin
			for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
			top = top >> 1;
		end
		while (top < (64'd1 << SCALE_LO)) begin
			for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
			top = top << 1;
		end
		return 1'b1;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// zero vector maps to zero
	function automatic void unit_vec(input bit n[3], input logic [63:0] m[3],
	                                 output longint o[3]);
		logic [63:0] sum;
		logic [63:0] len;
		sum = 0;
		if (!block_align(m)) begin
			for (int i = 0; i < 3; i++) o[i] = 0;
			return;
		end
		for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) o[i] = clip_word(n[i], (m[i] << FRAC_BITS) / len);
	endfunction

	function automatic logic [63:0] lim31(longint v);
		logic [63:0] mg;
		mg = abs64(v);
		return (mg > (64'd1 << 31)) ? (64'd1 << 31) : mg;
	endfunction

	// exact cross product in sign-magnitude, operands limited to 2^31
	function automatic void cross_exact(input longint a[3], input longint b[3],
	                                    output bit n[3], output logic [63:0] m[3]);
		int j;
		int k;
		bit pn;
		bit qn;
		logic [63:0] pm;
		logic [63:0] qm;
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			k = (i + 2) % 3;
			pn = (a[j] < 0) != (b[k] < 0);
			qn = !((a[k] < 0) != (b[j] < 0));
			pm = lim31(a[j]) * lim31(b[k]);
			qm = lim31(a[k]) * lim31(b[j]);
			if (pn == qn) begin
				n[i] = pn; m[i] = pm + qm;
			end else if (pm >= qm) begin
				n[i] = pn; m[i] = pm - qm;
			end else begin
				n[i] = qn; m[i] = qm - pm;
			end
		end
	endfunction

	function automatic void cross_fixed(input longint a[3], input longint b[3],
	                                    output longint o[3]);
		bit n[3];
		logic [63:0] m[3];
		cross_exact(a, b, n, m);
		for (int i = 0; i < 3; i++) o[i] = clip_word(n[i], m[i] >> FRAC_BITS);
	endfunction

	// -dot(axis, eye), floored to the fixed-point grid and saturated
	function automatic longint neg_dot(longint ax[3], longint eye[3]);
		logic signed [127:0] acc;
		logic signed [127:0] q;
		longint pr;
		acc = 0;
		for (int i = 0; i < 3; i++) begin
			pr = ax[i] * eye[i];
			acc = acc - pr;
		end
		q = acc >>> FRAC_BITS;
		if (q > 128'sd2147483647) return WORD_MAX;
		if (q < -128'sd2147483648) return WORD_MIN;
		return longint'(q);
	endfunction

	function automatic view_t predict_view(cam_item_t it);
		bit n[3];
		logic [63:0] m[3];
		longint hs[3];
		view_t v;
		for (int i = 0; i < 3; i++) cam_eye[i] = it.pos[i];
		if (it.op == OP_LOOK_AT) begin
			for (int i = 0; i < 3; i++) begin
				n[i] = it.pos[i] < it.tgt[i];
				m[i] = abs64(it.pos[i] - it.tgt[i]);
			end
			unit_vec(n, m, cam_fwd);
			for (int i = 0; i < 3; i++) begin
				n[i] = it.hint[i] < 0;
				m[i] = abs64(it.hint[i]);
			end
			void'(block_align(m));
			for (int i = 0; i < 3; i++) hs[i] = n[i] ? -longint'(m[i]) : longint'(m[i]);
			cross_exact(hs, cam_fwd, n, m);
			unit_vec(n, m, cam_rgt);
			cross_fixed(cam_fwd, cam_rgt, cam_upw);
		end
		// re-orthonormalize the stored basis on every item
		for (int i = 0; i < 3; i++) begin
			n[i] = cam_fwd[i] < 0;
			m[i] = abs64(cam_fwd[i]);
		end
		unit_vec(n, m, cam_fwd);
		cross_exact(cam_fwd, cam_rgt, n, m);
		unit_vec(n, m, cam_upw);
		cross_fixed(cam_upw, cam_fwd, cam_rgt);
		for (int i = 0; i < 3; i++) begin
			v[i]     = WORD_BITS'(cam_rgt[i]);
			v[3 + i] = WORD_BITS'(cam_upw[i]);
			v[6 + i] = WORD_BITS'(cam_fwd[i]);
		end
		v[9]  = WORD_BITS'(neg_dot(cam_rgt, cam_eye));
		v[10] = WORD_BITS'(neg_dot(cam_upw, cam_eye));
		v[11] = WORD_BITS'(neg_dot(cam_fwd, cam_eye));
		return v;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers
	function automatic longint rand_word();
		int sel;
		sel = $urandom_range(0, 11);
		case (sel)
			0, 1, 2, 3: return longint'($signed($urandom));
			4, 5, 6, 7: return longint'($urandom_range(0, 2 ** 21)) - 2 ** 20;
			8, 9:       return longint'($urandom_range(0, 2 ** 27)) - 2 ** 26;
			10:         return longint'($urandom_range(0, 2 ** 4)) - 2 ** 3;
			default: begin
				case ($urandom_range(0, 4))
					0: return 0;
					1: return WORD_MAX;
					2: return WORD_MIN;
					3: return 65536;
					default: return -65536;
				endcase
			end
		endcase
	endfunction

	function automatic cam_item_t make_item(logic op, longint px, longint py, longint pz,
	                                        longint tx, longint ty, longint tz,
	                                        longint hx, longint hy, longint hz);
		cam_item_t it;
		it.op = op;
		it.pos[0] = px; it.pos[1] = py; it.pos[2] = pz;
		it.tgt[0] = tx; it.tgt[1] = ty; it.tgt[2] = tz;
		it.hint[0] = hx; it.hint[1] = hy; it.hint[2] = hz;
		return it;
	endfunction

	function automatic cam_item_t rand_item();
		cam_item_t it;
		int shape;
		it.op = ($urandom_range(0, 99) < 45) ? OP_LOOK_AT : OP_SET_POS;
		for (int i = 0; i < 3; i++) begin
			it.pos[i] = rand_word();
			it.tgt[i] = rand_word();
			it.hint[i] = rand_word();
		end
		shape = $urandom_range(0, 19);
		// a few degenerate geometries: eye on target, no hint, hint along the view
		if (shape == 0) for (int i = 0; i < 3; i++) it.tgt[i] = it.pos[i];
		if (shape == 1) for (int i = 0; i < 3; i++) it.hint[i] = 0;
		if (shape == 2) for (int i = 0; i < 3; i++)
			it.hint[i] = longint'($signed(WORD_BITS'(it.pos[i] - it.tgt[i])));
		return it;
	endfunction

	// ---------------------------------------------------------------- checking
	task automatic compare_view(view_t got, view_t want);
		string tag[12];
		tag = '{"right_x", "right_y", "right_z", "upward_x", "upward_y", "upward_z",
		        "forward_x", "forward_y", "forward_z", "shift_x", "shift_y", "shift_z"};
		for (int i = 0; i < 12; i++) begin
			if (got[i] !== want[i]) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("mismatch on result %0d, %s: expected %h, got %h",
					         checked_cnt, tag[i], want[i], got[i]);
			end
		end
	endtask

	// ---------------------------------------------------------------- clock
	initial begin
		clk = 1'b0;
		forever #(HALF_PERIOD) clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#(100_000_000);
		$display("tb: failure");
		$finish;
	end

	// ---------------------------------------------------------------- driver
	// advance to the next pending item once the current one transfers
	always @(posedge clk) begin
		if (drive_en) begin
			if (in_valid && in_ready) begin
				expected_views.push_back(predict_view(cur_item));
				sent_cnt++;
				if (cur_item.op == OP_LOOK_AT) look_cnt++;
				else setpos_cnt++;
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
					cur_item = pending_items.pop_front();
					in_valid  <= 1'b1;
					operation <= cur_item.op;
					pos_x <= word_t'(cur_item.pos[0]);
					pos_y <= word_t'(cur_item.pos[1]);
					pos_z <= word_t'(cur_item.pos[2]);
					target_x <= word_t'(cur_item.tgt[0]);
					target_y <= word_t'(cur_item.tgt[1]);
					target_z <= word_t'(cur_item.tgt[2]);
					up_hint_x <= word_t'(cur_item.hint[0]);
					up_hint_y <= word_t'(cur_item.hint[1]);
					up_hint_z <= word_t'(cur_item.hint[2]);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// switch idling profile as the run advances
	always @(posedge clk) begin
		if (sent_cnt < PHASE_A_END) begin
			snd_idle_pct <= 20;
			rcv_idle_pct <= 61;
		end else if (sent_cnt < PHASE_B_END) begin
			snd_idle_pct <= 61;
			rcv_idle_pct <= 20;
		end else begin
			snd_idle_pct <= 0;
			rcv_idle_pct <= 0;
		end
	end

	// ---------------------------------------------------------------- hold-off
	// count down one long receiver hold-off so the core backs up into its input
	always @(posedge clk) begin
		if (drive_en) begin
			if (!hold_done && sent_cnt >= HOLD_AT) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				if (in_valid && !in_ready) stall_cnt <= stall_cnt + 1;
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	// check every output transfer, then pick the next ready level
	always @(posedge clk) begin
		if (drive_en) begin
			if (out_valid && out_ready) begin
				if (expected_views.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected result transfer with nothing pending");
				end else begin
					compare_view({shift_z, shift_y, shift_x,
					              forward_z, forward_y, forward_x,
					              upward_z, upward_y, upward_x,
					              right_z, right_y, right_x},
					             expected_views.pop_front());
				end
				checked_cnt++;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
			end
		end
	end

	// ---------------------------------------------------------------- sequence
	initial begin
		arst_n = 1'b0;
		drive_en = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		operation = OP_LOOK_AT;
		pos_x = '0; pos_y = '0; pos_z = '0;
		target_x = '0; target_y = '0; target_z = '0;
		up_hint_x = '0; up_hint_y = '0; up_hint_z = '0;
		sent_cnt = 0; look_cnt = 0; setpos_cnt = 0; checked_cnt = 0;
		mismatch_cnt = 0; hold_left = 0; hold_done = 1'b0; stall_cnt = 0;
		snd_idle_pct = 20; rcv_idle_pct = 61;
		for (int i = 0; i < 3; i++) begin
			cam_rgt[i] = 0; cam_upw[i] = 0; cam_fwd[i] = 0; cam_eye[i] = 0;
		end
		cam_rgt[0] = 1 << FRAC_BITS;
		cam_upw[1] = 1 << FRAC_BITS;
		cam_fwd[2] = 1 << FRAC_BITS;

		// directed: reset basis, extremes, degenerate geometry, both operations
		pending_items.push_back(make_item(OP_SET_POS, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(OP_SET_POS, 65536, -131072, 327680, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(OP_LOOK_AT, 0, 0, 5 << 16, 0, 0, 0, 0, 1 << 16, 0));
		pending_items.push_back(make_item(OP_LOOK_AT, 3 << 16, 2 << 16, 1 << 16,
		                                  0, 0, 0, 0, 1 << 16, 0));
		pending_items.push_back(make_item(OP_SET_POS, WORD_MAX, WORD_MAX, WORD_MAX,
		                                  0, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(OP_SET_POS, WORD_MIN, WORD_MIN, WORD_MIN,
		                                  WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
		pending_items.push_back(make_item(OP_LOOK_AT, 1 << 16, 1 << 16, 1 << 16,
		                                  1 << 16, 1 << 16, 1 << 16, 0, 1 << 16, 0));
		pending_items.push_back(make_item(OP_LOOK_AT, 0, 0, 4 << 16, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(OP_LOOK_AT, 0, 0, 4 << 16, 0, 0, 0, 0, 0, 7 << 16));
		pending_items.push_back(make_item(OP_LOOK_AT, WORD_MIN, WORD_MIN, WORD_MIN,
		                                  WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN));
		pending_items.push_back(make_item(OP_LOOK_AT, WORD_MAX, WORD_MIN, WORD_MAX,
		                                  WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX));
		pending_items.push_back(make_item(OP_LOOK_AT, 1, 0, 0, 0, 0, 0, 0, 1, 0));
		pending_items.push_back(make_item(OP_LOOK_AT, -1, -1, -1, 0, 0, 0, -1, 1, -1));
		pending_items.push_back(make_item(OP_SET_POS, -1, 1, -1, 5, 5, 5, 5, 5, 5));
		pending_items.push_back(make_item(OP_SET_POS, WORD_MAX, WORD_MIN, 0, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(OP_LOOK_AT, 10 << 16, 0, 0, 0, 0, 0,
		                                  WORD_MIN, WORD_MIN, WORD_MIN));
		pending_items.push_back(make_item(OP_SET_POS, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		for (int n = 0; n < RANDOM_ITEMS; n++) pending_items.push_back(rand_item());

		repeat (12) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		drive_en = 1'b1;

		// drain: all items sent, all results back, then a quiet tail
		while (pending_items.size() > 0 || in_valid || expected_views.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_views.size() > 0) mismatch_cnt++;

		$display("covered %0d look-at and %0d set-position transfers, %0d results checked",
		         look_cnt, setpos_cnt, checked_cnt);
		$display("input stalled %0d cycles during the long output hold-off, %0d mismatches",
		         stall_cnt, mismatch_cnt);
		if (mismatch_cnt == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
